@@ sv/rpn_stack_calculator_unit_macros.svh @@
// Assertion shorthands for the RPN calculator; each use samples on clk
// and is held off while arst_n is low.
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RPNSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that a condition never holds outside reset.
`define RPNSC_NEVER(lbl, expr, msg) \
	`RPNSC_ASSERT(lbl, !(expr), msg)

`endif

@@ sv/rpnsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rpnsc_pkg;

	// Fixed field widths
	localparam int WORD_W   = 32;
	localparam int MODE_W   = 4;
	localparam int STATUS_W = 3;
	localparam int IT_W     = 5;
	localparam logic [IT_W-1:0] IT_LAST = IT_W'(WORD_W - 1);

	// Operation codes
	typedef enum logic [MODE_W-1:0] {
		OP_PUSH  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_NEG   = 4'd5,
		OP_DUP   = 4'd6,
		OP_SWAP  = 4'd7,
		OP_PEEK  = 4'd8,
		OP_CLEAR = 4'd9,
		OP_LIST  = 4'd10
	} op_t;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		STS_DONE    = 3'd0,
		STS_VALUE   = 3'd1,
		STS_FEW     = 3'd2,
		STS_DIVZERO = 3'd3,
		STS_EMPTY   = 3'd4,
		STS_FULL    = 3'd5
	} status_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_RD1,
		ST_RD2,
		ST_ALU,
		ST_DIVA,
		ST_DIVB,
		ST_LOOP,
		ST_FIX,
		ST_WB,
		ST_SWAP2,
		ST_EMIT,
		ST_LIST
	} state_t;

endpackage

`default_nettype wire

@@ sv/rpnsc_cmd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Command channel: one operation per word
interface rpnsc_cmd_if import rpnsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic signed [WORD_W-1:0] push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink (input valid, input mode, input push_value, output ready);
endinterface

`default_nettype wire

@@ sv/rpnsc_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Response channel: status, reported value and last-word mark
interface rpnsc_rsp_if import rpnsc_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic signed [WORD_W-1:0] result_value;
	logic                     last;

	modport source (output valid, output status, output result_value, output last,
		input ready);
	modport sink (input valid, input status, input result_value, input last,
		output ready);
endinterface

`default_nettype wire

@@ sv/rpnsc_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module rpnsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/rpn_stack_calculator_unit.sv @@
// RPN integer calculator on a stack of STACK_DEPTH 32-bit entries.
// cmd (sink) takes one operation word: mode and push_value. rsp (source)
// gives status, result_value and last for each result word.
// The block takes one command at a time; cmd.ready is high only while idle,
// and it stays high even when a finished result still waits in the output
// register. After decode, a command reads its operands, uses the adder
// and writes back as its mode needs; an error skips to the result word.
// Multiply and divide run a 32-step loop through the single shared 33-bit
// adder (one multiplier bit or one quotient bit per cycle); divide adds
// three adder passes for the operand magnitudes and the quotient sign.
// Stack entries live in a RAM with one registered read port, so each
// operand is read through that port. Once a list starts it gives one
// word per cycle from the top entry down while rsp is not stalled, the
// final one marked last. The next command can be accepted in the cycle
// after the current result word is loaded. Reset empties the stack and
// clears any pending output; RAM contents are left as they are. A stalled
// receiver holds the output word and the sequencer waits for it.
`timescale 1ns / 1ps
`default_nettype none
`include "rpn_stack_calculator_unit_macros.svh"

module rpn_stack_calculator_unit import rpnsc_pkg::*; #(
	parameter int STACK_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	rpnsc_cmd_if.sink   cmd,
	rpnsc_rsp_if.source rsp
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	state_t            state_q, state_d;
	logic [CW-1:0]     cnt_q;
	op_t               mode_q;
	logic [WORD_W-1:0] pv_q;
	logic [WORD_W-1:0] a_q, b_q, acc_q;
	logic [IT_W-1:0]   it_q;
	logic              neg_q;
	logic [AW-1:0]     list_idx_q;
	status_t           pst_q;
	logic [WORD_W-1:0] pval_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [WORD_W-1:0] out_value_q;
	logic              out_last_q;

	// Stack view
	logic          few1, few2, full;
	logic [AW-1:0] top_addr, sec_addr;

	// RAM ports
	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	// Shared adder
	logic [WORD_W:0]   add_x, add_y;
	logic              add_sub;
	logic [WORD_W+1:0] add_sum;

	// Control from the sequencer
	logic              in_ready, out_free, out_load;
	status_t           out_status_d;
	logic [WORD_W-1:0] out_value_d;
	logic              out_last_d;
	logic              pend_load;
	status_t           pend_status;
	logic [WORD_W-1:0] pend_value;
	logic              cnt_inc, cnt_dec, cnt_clr;

	assign few1     = (cnt_q == '0);
	assign few2     = (cnt_q < CW'(2));
	assign full     = (cnt_q == CW'(STACK_DEPTH));
	assign top_addr = AW'(cnt_q - CW'(1));
	assign sec_addr = AW'(cnt_q - CW'(2));
	assign out_free = !out_valid_q || rsp.ready;

	// Shared adder: x + y, or x - y with carry out meaning no borrow
	assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {(WORD_W + 1){add_sub}}}
		+ (WORD_W + 2)'(add_sub);

	rpnsc_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (mode_q)
					OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
						state_d = few2 ? ST_EMIT : ST_RD1;
					end
					OP_NEG, OP_PEEK: begin
						state_d = few1 ? ST_EMIT : ST_RD1;
					end
					OP_DUP: begin
						state_d = (few1 || full) ? ST_EMIT : ST_RD1;
					end
					OP_LIST: begin
						state_d = few1 ? ST_EMIT : ST_LIST;
					end
					default: begin
						state_d = ST_EMIT;
					end
				endcase
			end
			ST_RD1: begin
				case (mode_q)
					OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: state_d = ST_RD2;
					OP_NEG:                                  state_d = ST_ALU;
					default:                                 state_d = ST_EMIT;
				endcase
			end
			ST_RD2: begin
				case (mode_q)
					OP_DIV:  state_d = (b_q == '0) ? ST_EMIT : ST_DIVA;
					OP_MUL:  state_d = ST_LOOP;
					OP_SWAP: state_d = ST_SWAP2;
					default: state_d = ST_ALU;
				endcase
			end
			ST_ALU:   state_d = ST_WB;
			ST_DIVA:  state_d = ST_DIVB;
			ST_DIVB:  state_d = ST_LOOP;
			ST_LOOP: begin
				if (it_q == IT_LAST) begin
					state_d = (mode_q == OP_DIV) ? ST_FIX : ST_WB;
				end
			end
			ST_FIX:   state_d = ST_WB;
			ST_WB:    state_d = ST_EMIT;
			ST_SWAP2: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_LIST: begin
				if (out_free && list_idx_q == '0) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: command ready, RAM access, adder operands, stack count, result
	always_comb begin
		in_ready     = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = top_addr;
		ram_wdata    = acc_q;
		ram_re       = 1'b0;
		ram_raddr    = top_addr;
		add_x        = '0;
		add_y        = '0;
		add_sub      = 1'b0;
		pend_load    = 1'b0;
		pend_status  = STS_DONE;
		pend_value   = '0;
		cnt_inc      = 1'b0;
		cnt_dec      = 1'b0;
		cnt_clr      = 1'b0;
		out_load     = 1'b0;
		out_status_d = pst_q;
		out_value_d  = pval_q;
		out_last_d   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_DECODE: begin
				pend_load = 1'b1;
				case (mode_q)
					OP_PUSH: begin
						if (full) begin
							pend_status = STS_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = AW'(cnt_q);
							ram_wdata = pv_q;
							cnt_inc   = 1'b1;
						end
					end
					OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
						pend_status = STS_FEW;
						ram_re      = !few2;
					end
					OP_NEG, OP_PEEK: begin
						pend_status = STS_FEW;
						ram_re      = !few1;
					end
					OP_DUP: begin
						pend_status = few1 ? STS_FEW : STS_FULL;
						ram_re      = !(few1 || full);
					end
					OP_CLEAR: begin
						cnt_clr = 1'b1;
					end
					OP_LIST: begin
						pend_status = STS_EMPTY;
						ram_re      = !few1;
					end
					default: begin
						pend_status = STS_DONE;
					end
				endcase
			end
			ST_RD1: begin
				case (mode_q)
					OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SWAP: begin
						ram_re    = 1'b1;
						ram_raddr = sec_addr;
					end
					OP_DUP: begin
						ram_we    = 1'b1;
						ram_waddr = AW'(cnt_q);
						ram_wdata = ram_rdata;
						cnt_inc   = 1'b1;
						pend_load = 1'b1;
					end
					OP_PEEK: begin
						pend_load   = 1'b1;
						pend_status = STS_VALUE;
						pend_value  = ram_rdata;
					end
					default: begin
						pend_load = 1'b0;
					end
				endcase
			end
			ST_RD2: begin
				if (mode_q == OP_DIV && b_q == '0) begin
					pend_load   = 1'b1;
					pend_status = STS_DIVZERO;
				end
				if (mode_q == OP_SWAP) begin
					ram_we    = 1'b1;
					ram_waddr = top_addr;
					ram_wdata = ram_rdata;
				end
			end
			ST_ALU: begin
				case (mode_q)
					OP_ADD: begin
						add_x = {1'b0, a_q};
						add_y = {1'b0, b_q};
					end
					OP_SUB: begin
						add_x   = {1'b0, a_q};
						add_y   = {1'b0, b_q};
						add_sub = 1'b1;
					end
					default: begin
						add_y   = {1'b0, b_q};
						add_sub = 1'b1;
					end
				endcase
			end
			ST_DIVA: begin
				add_y   = {1'b0, a_q};
				add_sub = 1'b1;
			end
			ST_DIVB: begin
				add_y   = {1'b0, b_q};
				add_sub = 1'b1;
			end
			ST_LOOP: begin
				if (mode_q == OP_DIV) begin
					add_x   = {acc_q, a_q[WORD_W-1]};
					add_y   = {1'b0, b_q};
					add_sub = 1'b1;
				end else begin
					add_x = {1'b0, acc_q};
					add_y = {1'b0, a_q};
				end
			end
			ST_FIX: begin
				add_y   = {1'b0, a_q};
				add_sub = 1'b1;
			end
			ST_WB: begin
				ram_we    = 1'b1;
				ram_waddr = (mode_q == OP_NEG) ? top_addr : sec_addr;
				ram_wdata = acc_q;
				cnt_dec   = (mode_q != OP_NEG);
				pend_load = 1'b1;
			end
			ST_SWAP2: begin
				ram_we    = 1'b1;
				ram_waddr = sec_addr;
				ram_wdata = b_q;
				pend_load = 1'b1;
			end
			ST_EMIT: begin
				out_load = out_free;
			end
			ST_LIST: begin
				out_load     = out_free;
				out_status_d = STS_VALUE;
				out_value_d  = ram_rdata;
				out_last_d   = (list_idx_q == '0);
				ram_re       = out_free && (list_idx_q != '0);
				ram_raddr    = list_idx_q - AW'(1);
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign cmd.ready        = in_ready;
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.result_value = out_value_q;
	assign rsp.last         = out_last_q;

	// Advance the sequencer and track the stack depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Hold the output word until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= out_status_d;
			out_value_q  <= out_value_d;
			out_last_q   <= out_last_d;
		end
	end

	// Operand, accumulator and loop registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd.valid) begin
			mode_q <= op_t'(cmd.mode);
			pv_q   <= cmd.push_value;
		end
		if (pend_load) begin
			pst_q  <= pend_status;
			pval_q <= pend_value;
		end
		case (state_q)
			ST_DECODE: begin
				list_idx_q <= top_addr;
			end
			ST_RD1: begin
				b_q <= ram_rdata;
			end
			ST_RD2: begin
				a_q   <= ram_rdata;
				acc_q <= '0;
				it_q  <= '0;
				neg_q <= ram_rdata[WORD_W-1] ^ b_q[WORD_W-1];
			end
			ST_ALU: begin
				acc_q <= add_sum[WORD_W-1:0];
			end
			ST_DIVA: begin
				if (a_q[WORD_W-1]) begin
					a_q <= add_sum[WORD_W-1:0];
				end
			end
			ST_DIVB: begin
				if (b_q[WORD_W-1]) begin
					b_q <= add_sum[WORD_W-1:0];
				end
			end
			ST_LOOP: begin
				it_q <= it_q + IT_W'(1);
				if (mode_q == OP_DIV) begin
					// restoring step: keep the difference when it did not borrow
					if (add_sum[WORD_W+1]) begin
						acc_q <= add_sum[WORD_W-1:0];
					end else begin
						acc_q <= {acc_q[WORD_W-2:0], a_q[WORD_W-1]};
					end
					a_q <= {a_q[WORD_W-2:0], add_sum[WORD_W+1]};
				end else begin
					// shift-add: add the multiplicand for each set multiplier bit
					if (b_q[0]) begin
						acc_q <= add_sum[WORD_W-1:0];
					end
					a_q <= {a_q[WORD_W-2:0], 1'b0};
					b_q <= {1'b0, b_q[WORD_W-1:1]};
				end
			end
			ST_FIX: begin
				acc_q <= neg_q ? add_sum[WORD_W-1:0] : a_q;
			end
			ST_LIST: begin
				if (out_free && list_idx_q != '0) begin
					list_idx_q <= list_idx_q - AW'(1);
				end
			end
			default: begin
				it_q <= it_q;
			end
		endcase
	end

	`RPNSC_ASSERT(a_accept_decode, (cmd.valid && cmd.ready) |=> (state_q == ST_DECODE), "accepted word did not start decode")
	`RPNSC_ASSERT(a_idle_count, (state_q == ST_IDLE) |=> $stable(cnt_q), "stack count moved while idle")
	`RPNSC_ASSERT(a_loop_runs, (state_q == ST_LOOP && it_q != IT_LAST) |=> (state_q == ST_LOOP), "iteration loop left early")
	`RPNSC_NEVER(a_count_bound, cnt_q > CW'(STACK_DEPTH), "stack count beyond depth")

endmodule

`default_nettype wire
